[design/lgs_pkg.sv]
package lgs_pkg;

	// request kinds carried by req_type
	typedef enum logic [1:0] {
		REQ_WRITE   = 2'd0,
		REQ_READ    = 2'd1,
		REQ_ADVANCE = 2'd2,
		REQ_CLEAR   = 2'd3
	} lgs_req_t;

	// B3/S23 neighbor counts
	localparam logic [3:0] BIRTH_COUNT = 4'd3;
	localparam logic [3:0] STAY_COUNT  = 4'd2;

	// controller states, one-hot
	typedef enum logic [3:0] {
		ST_IDLE    = 4'b0001,
		ST_READ    = 4'b0010,
		ST_ADVANCE = 4'b0100,
		ST_CLEAR   = 4'b1000
	} lgs_state_t;

	// shift control shared by every cell of the line buffer
	typedef struct packed {
		logic en;
		logic clr;
	} lgs_shift_t;

endpackage

[design/lgs_cell.sv]
module lgs_cell (
	input  logic               clk,
	input  lgs_pkg::lgs_shift_t ctl,
	input  logic               d,
	output logic               q
);
	import lgs_pkg::*;

	logic bit_q;

	// flush to dead at the start of a sweep, otherwise pass the neighbor's bit along
	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			bit_q <= 1'b0;
		end else if (ctl.en) begin
			bit_q <= d;
		end
	end

	assign q = bit_q;

endmodule

[design/lgs_rule.sv]
module lgs_rule (
	input  logic [2:0][2:0] win,
	input  logic            first_col,
	input  logic            last_col,
	output logic            next
);
	import lgs_pkg::*;

	logic [3:0] count;

	// sum the eight neighbors, dropping the column that falls off the grid
	always_comb begin
		count = 4'd0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				if (!(r == 1 && c == 1) && !(c == 0 && first_col) && !(c == 2 && last_col)) begin
					count = count + 4'(win[r][c]);
				end
			end
		end
	end

	// birth on three, survive on two or three
	assign next = (count == BIRTH_COUNT) || (win[1][1] && (count == STAY_COUNT));

endmodule

[design/life_grid_generation_step.sv]
// Game of Life (B3/S23) engine over a GRID_WIDTH x GRID_HEIGHT grid of one-bit cells, dead
// beyond the edges, no wrap. Issue a word with start while busy is low; its result shows on
// read_value and generation_number for exactly one cycle with done high, and cannot be held
// off. A cell write leaves busy low; a cell read, a clear and an advance hold busy high until
// done rises, and busy is low again in the cycle in which done is high. A clear zeroes one
// cell per cycle through the single write port. An advance sweeps the grid memory once
// through its single read port into a line buffer of 2*GRID_WIDTH+3 shift cells, and each
// new cell is written back in place once its whole neighborhood has passed. After reset the
// block runs a clearing pass over every cell with busy high and no done pulse.
module life_grid_generation_step #(
	parameter int GRID_WIDTH  = 64,
	parameter int GRID_HEIGHT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [1:0]  req_type,
	input  logic [5:0]  cell_x,
	input  logic [5:0]  cell_y,
	input  logic        cell_value,
	output logic        busy,
	output logic        done,
	output logic        read_value,
	output logic [31:0] generation_number
);
	import lgs_pkg::*;

	localparam int N  = GRID_WIDTH * GRID_HEIGHT;
	localparam int AW = $clog2(N);
	localparam int KW = $clog2(N + GRID_WIDTH + 1);
	localparam int XW = $clog2(GRID_WIDTH);
	localparam int L  = 2 * GRID_WIDTH + 3;

	lgs_state_t     state_q;
	logic           init_q;
	logic           done_q;
	logic           read_value_q;
	logic [31:0]    gen_q;
	logic           on_grid_q;
	logic [KW-1:0]  k_q;
	logic           sweep_q;
	logic [AW-1:0]  ca_q;
	logic [XW-1:0]  col_q;
	logic           v_s1;
	logic [KW-1:0]  k_s1;
	logic           in_grid_s1;
	logic           rdata_s1;
	logic           wv_s2;
	logic [AW-1:0]  wa_s2;
	logic [XW-1:0]  wx_s2;

	logic           accept;
	logic           on_grid;
	logic [AW-1:0]  in_addr;
	logic [AW-1:0]  ra;
	logic           we;
	logic [AW-1:0]  wa;
	logic           wd;
	logic           new_cell;
	lgs_shift_t     shift_ctl;
	logic [L-1:0]   chain;
	logic [2:0][2:0] win;

	logic mem [N];

	assign accept  = start && !busy;
	assign on_grid = (32'(cell_x) < GRID_WIDTH) && (32'(cell_y) < GRID_HEIGHT);
	assign in_addr = AW'(cell_y) * AW'(GRID_WIDTH) + AW'(cell_x);

	// pick the memory ports: sweep, clearing pass, or a single word
	always_comb begin
		ra = (state_q == ST_ADVANCE) ? k_q[AW-1:0] : in_addr;
		we = 1'b0;
		wa = in_addr;
		wd = cell_value;
		case (state_q)
			ST_ADVANCE: begin
				we = wv_s2;
				wa = wa_s2;
				wd = new_cell;
			end
			ST_CLEAR: begin
				we = 1'b1;
				wa = k_q[AW-1:0];
				wd = 1'b0;
			end
			ST_IDLE: begin
				we = accept && (lgs_req_t'(req_type) == REQ_WRITE) && on_grid;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// grid memory, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rdata_s1 <= mem[ra];
	end

	// line buffer of shift cells
	assign shift_ctl.en  = v_s1;
	assign shift_ctl.clr = accept && (lgs_req_t'(req_type) == REQ_ADVANCE);

	for (genvar j = 0; j < L; j++) begin : g_cell
		if (j == 0) begin : g_head
			lgs_cell u_cell (
				.clk(clk),
				.ctl(shift_ctl),
				.d  (in_grid_s1 & rdata_s1),
				.q  (chain[0])
			);
		end else begin : g_body
			lgs_cell u_cell (
				.clk(clk),
				.ctl(shift_ctl),
				.d  (chain[j-1]),
				.q  (chain[j])
			);
		end
	end

	// tap the 3x3 neighborhood centered on position GRID_WIDTH+1
	assign win[0][0] = chain[2*GRID_WIDTH+2];
	assign win[0][1] = chain[2*GRID_WIDTH+1];
	assign win[0][2] = chain[2*GRID_WIDTH];
	assign win[1][0] = chain[GRID_WIDTH+2];
	assign win[1][1] = chain[GRID_WIDTH+1];
	assign win[1][2] = chain[GRID_WIDTH];
	assign win[2][0] = chain[2];
	assign win[2][1] = chain[1];
	assign win[2][2] = chain[0];

	lgs_rule u_rule (
		.win      (win),
		.first_col(wx_s2 == '0),
		.last_col (wx_s2 == XW'(GRID_WIDTH - 1)),
		.next     (new_cell)
	);

	// sequence requests, sweeps and results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			init_q       <= 1'b1;
			done_q       <= 1'b0;
			read_value_q <= 1'b0;
			gen_q        <= '0;
			on_grid_q    <= 1'b0;
			k_q          <= '0;
			sweep_q      <= 1'b0;
			ca_q         <= '0;
			col_q        <= '0;
			v_s1         <= 1'b0;
			k_s1         <= '0;
			in_grid_s1   <= 1'b0;
			wv_s2        <= 1'b0;
			wa_s2        <= '0;
			wx_s2        <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (lgs_req_t'(req_type))
							REQ_WRITE: begin
								done_q       <= 1'b1;
								read_value_q <= 1'b0;
							end
							REQ_READ: begin
								on_grid_q <= on_grid;
								state_q   <= ST_READ;
							end
							REQ_ADVANCE: begin
								k_q     <= '0;
								sweep_q <= 1'b1;
								ca_q    <= '0;
								col_q   <= '0;
								state_q <= ST_ADVANCE;
							end
							REQ_CLEAR: begin
								k_q     <= '0;
								state_q <= ST_CLEAR;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_READ: begin
					done_q       <= 1'b1;
					read_value_q <= rdata_s1 & on_grid_q;
					state_q      <= ST_IDLE;
				end
				ST_ADVANCE: begin
					// issue reads, then push zeros for the rows below the grid
					if (sweep_q) begin
						if (k_q == KW'(N + GRID_WIDTH)) begin
							sweep_q <= 1'b0;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
					v_s1       <= sweep_q;
					k_s1       <= k_q;
					in_grid_s1 <= k_q < KW'(N);
					// the center becomes valid once the line buffer is primed
					wv_s2 <= 1'b0;
					if (v_s1 && (k_s1 >= KW'(GRID_WIDTH + 1))) begin
						wv_s2 <= 1'b1;
						wa_s2 <= ca_q;
						wx_s2 <= col_q;
						ca_q  <= ca_q + 1'b1;
						col_q <= (col_q == XW'(GRID_WIDTH - 1)) ? '0 : col_q + 1'b1;
					end
					// commit the last cell and report
					if (wv_s2 && (wa_s2 == AW'(N - 1))) begin
						done_q       <= 1'b1;
						read_value_q <= 1'b0;
						gen_q        <= gen_q + 32'd1;
						state_q      <= ST_IDLE;
					end
				end
				ST_CLEAR: begin
					if (k_q == KW'(N - 1)) begin
						done_q       <= !init_q;
						init_q       <= 1'b0;
						read_value_q <= 1'b0;
						gen_q        <= '0;
						state_q      <= ST_IDLE;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy              = (state_q != ST_IDLE);
	assign done              = done_q;
	assign read_value        = read_value_q;
	assign generation_number = gen_q;

	// a write-back never lands at or ahead of the read sweep
	a_wb_behind_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADVANCE && wv_s2) |-> (KW'(wa_s2) < k_q))
		else $error("write-back overtook the read sweep");

	// no sweep traffic outside an advance
	a_pipe_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_ADVANCE) |-> (!wv_s2 && !v_s1 && !sweep_q))
		else $error("sweep pipeline active outside an advance");

	// a result only leaves once the controller is back to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == ST_IDLE))
		else $error("result strobe while busy");

	// the last write-back of an advance bumps the counter by one
	a_gen_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADVANCE && wv_s2 && wa_s2 == AW'(N - 1))
		|=> (done_q && gen_q == $past(gen_q) + 32'd1))
		else $error("generation count did not advance");

endmodule

[tb/life_grid_generation_step_tb.sv]
module life_grid_generation_step_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lgs_pkg::*;

	localparam int DIRECTED_ROWS = 23;
	localparam int RANDOM_WORDS  = 117;
	localparam int QUIET_TAIL    = 25;
	localparam int DRAIN_AT      = 60;
	localparam int DRAIN_LIMIT   = 10000;
	localparam int SETTLE_CYCLES = 4200;

	// one stimulus word, with an optional hand-written result
	typedef struct {
		lgs_req_t    kind;
		logic [5:0]  x;
		logic [5:0]  y;
		logic        v;
		bit          typed;
		logic        rd;
		logic [31:0] gen;
	} stim_row_t;

	// one expected result word
	typedef struct {
		lgs_req_t    kind;
		logic        rd;
		logic [31:0] gen;
	} life_result_t;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        start      = 1'b0;
	logic [1:0]  req_type   = 2'b00;
	logic [5:0]  cell_x     = 6'd0;
	logic [5:0]  cell_y     = 6'd0;
	logic        cell_value = 1'b0;
	logic        busy;
	logic        done;
	logic        read_value;
	logic [31:0] generation_number;

	// hand-written result travelling alongside the word on the ports
	bit          word_typed = 1'b0;
	logic        golden_rd  = 1'b0;
	logic [31:0] golden_gen = 32'd0;

	// predicted board and generation counter
	bit [63:0]   board_now [64];
	logic [31:0] gen_count = 32'd0;

	life_result_t pending_results [$];
	int           mismatches = 0;
	int           results_seen = 0;
	int           words_by_kind [4] = '{default: 0};

	life_grid_generation_step DUT (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.req_type          (req_type),
		.cell_x            (cell_x),
		.cell_y            (cell_y),
		.cell_value        (cell_value),
		.busy              (busy),
		.done              (done),
		.read_value        (read_value),
		.generation_number (generation_number)
	);

	always #4 clk = ~clk;

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("MISMATCH at %0t ns: %s", $time, what);
	endtask

	// cells off the board count as dead
	function automatic bit alive_at(input int x, input int y);
		if (x < 0 || y < 0 || x > 63 || y > 63)
			return 1'b0;
		return board_now[y][x];
	endfunction

	// compute the whole next generation from the old board, then commit
	function automatic void advance_board();
		bit [63:0] nxt [64];
		int        cnt;
		for (int y = 0; y < 64; y++) begin
			for (int x = 0; x < 64; x++) begin
				cnt = 0;
				for (int dy = -1; dy <= 1; dy++)
					for (int dx = -1; dx <= 1; dx++)
						if (dx != 0 || dy != 0)
							cnt += alive_at(x + dx, y + dy);
				nxt[y][x] = (cnt == 3) || (board_now[y][x] && cnt == 2);
			end
		end
		board_now = nxt;
	endfunction

	function automatic life_result_t apply_life_request(input lgs_req_t kind,
			input logic [5:0] x, input logic [5:0] y, input logic v);
		life_result_t r;
		r.kind = kind;
		r.rd   = 1'b0;
		case (kind)
			REQ_WRITE: begin
				board_now[y][x] = v;
			end
			REQ_READ: begin
				r.rd = board_now[y][x];
			end
			REQ_ADVANCE: begin
				advance_board();
				gen_count = gen_count + 32'd1;
			end
			REQ_CLEAR: begin
				foreach (board_now[i])
					board_now[i] = '0;
				gen_count = 32'd0;
			end
			default: begin
				r.rd = 1'b0;
			end
		endcase
		r.gen = gen_count;
		return r;
	endfunction

	// place a window at an edge or anywhere, so patterns meet the border often
	function automatic int pick_origin();
		case ($urandom_range(3))
			0: return 0;
			1: return 56;
			default: return $urandom_range(56);
		endcase
	endfunction

	// mostly writes and reads inside a small window, so life develops there
	function automatic stim_row_t random_word(input int win_x, input int win_y);
		stim_row_t row;
		int        pick;
		pick      = $urandom_range(99);
		row.typed = 1'b0;
		row.rd    = 1'b0;
		row.gen   = 32'd0;
		row.v     = 1'($urandom_range(1));
		if ($urandom_range(99) < 85) begin
			row.x = 6'(win_x + $urandom_range(7));
			row.y = 6'(win_y + $urandom_range(7));
		end else begin
			row.x = 6'($urandom_range(63));
			row.y = 6'($urandom_range(63));
		end
		if (pick < 9) begin
			row.kind = REQ_ADVANCE;
		end else if (pick < 12) begin
			row.kind = REQ_CLEAR;
		end else if (pick < 40) begin
			row.kind = REQ_READ;
		end else begin
			row.kind = REQ_WRITE;
			row.v    = ($urandom_range(9) < 6);
		end
		return row;
	endfunction

	// present a word and hold it until the block takes it
	task automatic send_word(input stim_row_t row);
		req_type   <= row.kind;
		cell_x     <= row.x;
		cell_y     <= row.y;
		cell_value <= row.v;
		word_typed <= row.typed;
		golden_rd  <= row.rd;
		golden_gen <= row.gen;
		start      <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// check result words, then predict the word accepted at this edge
	always @(posedge clk) begin
		life_result_t want;
		if (arst_n) begin
			if (done) begin
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("result word with none pending: rd=%0b gen=%0d",
						read_value, generation_number));
				end else begin
					want = pending_results.pop_front();
					results_seen++;
					if (read_value !== want.rd)
						report_mismatch($sformatf("%s read_value: want %0b got %0b",
							want.kind.name(), want.rd, read_value));
					if (generation_number !== want.gen)
						report_mismatch($sformatf("%s generation_number: want %0d got %0d",
							want.kind.name(), want.gen, generation_number));
				end
			end
			if (start && !busy) begin
				want = apply_life_request(lgs_req_t'(req_type), cell_x, cell_y, cell_value);
				if (word_typed) begin
					want.rd  = golden_rd;
					want.gen = golden_gen;
				end
				pending_results.push_back(want);
				words_by_kind[req_type]++;
			end
		end
	end

	// abort a hung run
	initial begin
		#25_000_000;
		$display("Timed out with %0d result words pending", pending_results.size());
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		stim_row_t directed_rows [DIRECTED_ROWS];
		int        win_x;
		int        win_y;
		int        k;

		directed_rows = '{
			// empty board after reset
			'{REQ_READ,    6'd0,  6'd0,  1'b1, 1'b1, 1'b0, 32'd0},
			'{REQ_READ,    6'd63, 6'd63, 1'b0, 1'b1, 1'b0, 32'd0},
			// four lone corners
			'{REQ_WRITE,   6'd0,  6'd0,  1'b1, 1'b1, 1'b0, 32'd0},
			'{REQ_WRITE,   6'd63, 6'd0,  1'b1, 1'b1, 1'b0, 32'd0},
			'{REQ_WRITE,   6'd0,  6'd63, 1'b1, 1'b1, 1'b0, 32'd0},
			'{REQ_WRITE,   6'd63, 6'd63, 1'b1, 1'b1, 1'b0, 32'd0},
			'{REQ_READ,    6'd63, 6'd0,  1'b0, 1'b1, 1'b1, 32'd0},
			// lone corners starve
			'{REQ_ADVANCE, 6'd63, 6'd63, 1'b1, 1'b1, 1'b0, 32'd1},
			'{REQ_READ,    6'd0,  6'd0,  1'b0, 1'b1, 1'b0, 32'd1},
			// still block in the far corner, blinker against the left edge
			'{REQ_WRITE,   6'd62, 6'd62, 1'b1, 1'b0, 1'b0, 32'd0},
			'{REQ_WRITE,   6'd63, 6'd62, 1'b1, 1'b0, 1'b0, 32'd0},
			'{REQ_WRITE,   6'd62, 6'd63, 1'b1, 1'b0, 1'b0, 32'd0},
			'{REQ_WRITE,   6'd63, 6'd63, 1'b1, 1'b0, 1'b0, 32'd0},
			'{REQ_WRITE,   6'd1,  6'd0,  1'b1, 1'b0, 1'b0, 32'd0},
			'{REQ_WRITE,   6'd1,  6'd1,  1'b1, 1'b0, 1'b0, 32'd0},
			'{REQ_WRITE,   6'd1,  6'd2,  1'b1, 1'b0, 1'b0, 32'd0},
			'{REQ_ADVANCE, 6'd0,  6'd0,  1'b0, 1'b0, 1'b0, 32'd0},
			'{REQ_READ,    6'd0,  6'd1,  1'b1, 1'b0, 1'b0, 32'd0},
			'{REQ_READ,    6'd63, 6'd63, 1'b0, 1'b0, 1'b0, 32'd0},
			// break the block and let it evolve
			'{REQ_WRITE,   6'd63, 6'd63, 1'b0, 1'b0, 1'b0, 32'd0},
			'{REQ_ADVANCE, 6'd21, 6'd42, 1'b1, 1'b0, 1'b0, 32'd0},
			// clear ignores its coordinates and zeroes the counter
			'{REQ_CLEAR,   6'd63, 6'd63, 1'b1, 1'b1, 1'b0, 32'd0},
			'{REQ_READ,    6'd1,  6'd1,  1'b0, 1'b1, 1'b0, 32'd0}
		};

		// hold reset, then wait out the clearing pass through busy
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_word(directed_rows[i]);

		win_x = pick_origin();
		win_y = pick_origin();
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			// move the working window now and then
			if (i % 16 == 15) begin
				win_x = pick_origin();
				win_y = pick_origin();
			end
			send_word(random_word(win_x, win_y));
			if (i == DRAIN_AT) begin
				// drop start until every result word is back
				start <= 1'b0;
				do
					@(posedge clk);
				while (pending_results.size() != 0);
			end else if (i < RANDOM_WORDS - QUIET_TAIL && $urandom_range(99) < 30) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 17))
					@(posedge clk);
			end
		end
		start <= 1'b0;

		// drain, then watch for stray result words
		for (k = 0; k < DRAIN_LIMIT && pending_results.size() != 0; k++)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch($sformatf("%0d result words never arrived",
				pending_results.size()));

		$display("Sent %0d words: %0d writes, %0d reads, %0d advances, %0d clears.",
			DIRECTED_ROWS + RANDOM_WORDS, words_by_kind[REQ_WRITE], words_by_kind[REQ_READ],
			words_by_kind[REQ_ADVANCE], words_by_kind[REQ_CLEAR]);
		$display("Checked %0d result words, final generation %0d, %0d mismatches.",
			results_seen, gen_count, mismatches);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[files.f]
design/lgs_pkg.sv
design/lgs_cell.sv
design/lgs_rule.sv
design/life_grid_generation_step.sv
tb/life_grid_generation_step_tb.sv
